FILE: hdl/jtkl_pkg.sv
// Package for the top-level JSON key locator.
// Holds the transfer payload types, key configuration types and character codes.
// No dependencies.
`timescale 1ns / 1ps

package jtkl_pkg;

    localparam int KEY_MAX_BYTES = 16;
    localparam int KEY_REG_W     = 64;
    localparam int KEY_LEN_W     = 5;
    localparam int STR_LEN_W     = 5;
    localparam int VALUE_W       = 17;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
    localparam logic signed [7:0] DEPTH_MIN = -8'sd127;

    typedef struct packed {
        logic [7:0] doc_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value_offset;
    } t_out_item;

    typedef struct packed {
        logic [KEY_REG_W-1:0] key_bytes_low;
        logic [KEY_REG_W-1:0] key_bytes_high;
        logic [KEY_LEN_W-1:0] key_length;
    } t_key_cfg;

    typedef struct packed {
        logic      produced;
        logic      done;
        t_out_item item;
    } t_scan_res;

endpackage

FILE: hdl/jtkl_cfg_regs.sv
// Key configuration registers of the JSON key locator.
// Depends on jtkl_pkg for the register indexes and the t_key_cfg type.
`timescale 1ns / 1ps

module jtkl_cfg_regs
    import jtkl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [KEY_REG_W-1:0]   i_cfg_data,
    output t_key_cfg               o_cfg
);

    t_key_cfg r_cfg;
    t_key_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  n_cfg.key_bytes_low  = i_cfg_data;
                CFG_KEY_HIGH: n_cfg.key_bytes_high = i_cfg_data;
                CFG_KEY_LEN:  n_cfg.key_length     = i_cfg_data[KEY_LEN_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/jtkl_scanner.sv
// Per-byte document scanner: depth, string and escape tracking, key compare.
// Depends on jtkl_pkg for the payload, configuration and result types.
`timescale 1ns / 1ps

module jtkl_scanner
    import jtkl_pkg::*;
#(
    parameter int DOC_MAX_BYTES = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_key_cfg  i_cfg,
    output t_scan_res o_res
);

    localparam int POS_W = $clog2(DOC_MAX_BYTES + 2);
    localparam int OFS_W = POS_W + VALUE_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(DOC_MAX_BYTES);

    logic signed [7:0]    r_depth,    n_depth;
    logic                 r_in_str,   n_in_str;
    logic                 r_escaped,  n_escaped;
    logic [STR_LEN_W-1:0] r_str_len,  n_str_len;
    logic                 r_key_eq,   n_key_eq;
    logic                 r_await,    n_await;
    logic                 r_cand,     n_cand;
    logic [POS_W-1:0]     r_pos,      n_pos;
    logic                 r_done,     n_done;

    logic [7:0]                   c;
    logic                         blank;
    logic                         scan;
    logic                         hit;
    logic [2*KEY_REG_W-1:0]       key_all;
    logic [7:0]                   key_byte;
    logic [POS_W-1:0]             pos_inc;
    logic [POS_W-1:0]             ofs_sat;
    logic [OFS_W-1:0]             ofs_wide;

    assign c       = i_item.doc_byte;
    assign blank   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign key_all = {i_cfg.key_bytes_high, i_cfg.key_bytes_low};
    assign key_byte = key_all[{r_str_len[3:0], 3'b000} +: 8];
    assign pos_inc = r_pos + POS_W'(1);
    assign ofs_sat = (pos_inc > POS_LIMIT) ? POS_LIMIT : pos_inc;
    assign ofs_wide = OFS_W'(ofs_sat);

    always_comb begin
        n_depth   = r_depth;
        n_in_str  = r_in_str;
        n_escaped = r_escaped;
        n_str_len = r_str_len;
        n_key_eq  = r_key_eq;
        n_await   = r_await;
        n_cand    = r_cand;
        n_pos     = r_pos;
        n_done    = r_done;
        scan      = 1'b1;
        hit       = 1'b0;

        if (!r_done) begin
            if (r_await) begin
                if (blank) begin
                    scan = 1'b0;
                end else if (c == CH_COLON && r_cand) begin
                    hit     = 1'b1;
                    n_await = 1'b0;
                    scan    = 1'b0;
                end else begin
                    n_await = 1'b0;
                end
            end
            if (scan) begin
                if (r_in_str) begin
                    if (!r_escaped && c == CH_QUOTE) begin
                        n_in_str = 1'b0;
                        if (r_depth == 8'sd1) begin
                            n_await = 1'b1;
                            n_cand  = r_key_eq
                                && (i_cfg.key_length <= KEY_LEN_W'(KEY_MAX_BYTES))
                                && (r_str_len == i_cfg.key_length);
                        end
                    end else begin
                        // string content; a backslash arms the escape skip
                        n_escaped = !r_escaped && (c == CH_BSLASH);
                        if (r_str_len < STR_LEN_W'(KEY_MAX_BYTES) && key_byte != c) begin
                            n_key_eq = 1'b0;
                        end
                        if (r_str_len != '1) begin
                            n_str_len = r_str_len + STR_LEN_W'(1);
                        end
                    end
                end else if (c == CH_QUOTE) begin
                    n_in_str  = 1'b1;
                    n_escaped = 1'b0;
                    n_str_len = '0;
                    n_key_eq  = 1'b1;
                end else if (c == CH_LBRACE || c == CH_LBRACK) begin
                    if (r_depth < DEPTH_MAX) begin
                        n_depth = r_depth + 8'sd1;
                    end
                end else if (c == CH_RBRACE || c == CH_RBRACK) begin
                    if (r_depth > DEPTH_MIN) begin
                        n_depth = r_depth - 8'sd1;
                    end
                end
            end
            if (hit) begin
                n_done = 1'b1;
            end
        end

        if (r_pos < POS_LIMIT) begin
            n_pos = pos_inc;
        end

        // end of document: return to the reset state
        if (i_item.last_byte) begin
            n_depth   = '0;
            n_in_str  = 1'b0;
            n_escaped = 1'b0;
            n_str_len = '0;
            n_key_eq  = 1'b1;
            n_await   = 1'b0;
            n_cand    = 1'b0;
            n_pos     = '0;
            n_done    = 1'b0;
        end
    end

    always_comb begin
        o_res.done              = r_done;
        o_res.produced          = !r_done && (hit || i_item.last_byte);
        o_res.item.found        = hit;
        o_res.item.value_offset = hit ? ofs_wide[VALUE_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_in_str  <= 1'b0;
            r_escaped <= 1'b0;
            r_str_len <= '0;
            r_key_eq  <= 1'b1;
            r_await   <= 1'b0;
            r_cand    <= 1'b0;
            r_pos     <= '0;
            r_done    <= 1'b0;
        end else if (i_advance) begin
            r_depth   <= n_depth;
            r_in_str  <= n_in_str;
            r_escaped <= n_escaped;
            r_str_len <= n_str_len;
            r_key_eq  <= n_key_eq;
            r_await   <= n_await;
            r_cand    <= n_cand;
            r_pos     <= n_pos;
            r_done    <= n_done;
        end
    end

endmodule

FILE: hdl/json_top_level_key_locator_top.sv
// Top level of the JSON key locator: input register, scanner, result register.
// Depends on jtkl_pkg, jtkl_cfg_regs and jtkl_scanner.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one document
//   byte per transfer, with last_byte set on the final byte. The result
//   channel (o_out_valid / i_out_stall / o_out_item) carries at most one
//   result per document: found=1 with the offset just past the colon of the
//   first top-level member name equal to the key, or found=0 with offset 0
//   at the last byte when there is no hit.
//   The key is loaded through i_cfg_we / i_cfg_index / i_cfg_data while no
//   document is in flight: index 0 key bytes 0-7, 1 bytes 8-15, 2 length.
//   Throughput: one byte per clock while the result channel is not stalled;
//   the scanner state updates once per byte. A byte is held in the input
//   register while the scanner reads it, and its result is loaded into the
//   result register, which drives o_out_valid and o_out_item.
//   When the receiver stalls, the result register holds and one more byte
//   waits in the input register; o_in_stall rises after that.
//   Synchronous reset clears the key registers, the scan state and both
//   valid flags. State also returns to its reset values after each last byte.
`timescale 1ns / 1ps

module json_top_level_key_locator_top
    import jtkl_pkg::*;
#(
    parameter int DOC_MAX_BYTES = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [KEY_REG_W-1:0]   i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item
);

    t_key_cfg  cfg;
    t_scan_res scan_res;

    logic      r_s1_valid, n_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    logic out_free;
    logic s1_adv;
    logic in_xfer;

    jtkl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    jtkl_scanner #(
        .DOC_MAX_BYTES (DOC_MAX_BYTES)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_adv),
        .i_item    (r_s1_item),
        .i_cfg     (cfg),
        .o_res     (scan_res)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_adv && scan_res.produced) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv && scan_res.produced) begin
            r_out_item <= scan_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A not-found result always reports offset zero.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |-> o_out_item.value_offset == '0)
        else $error("not-found result with nonzero offset");

    // After a hit, bytes of the same document produce nothing.
    a_quiet_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && scan_res.done |-> !scan_res.produced)
        else $error("result produced after a hit");

    // Input stalls only while a byte waits behind a blocked result slot.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // A result loaded into the slot is presented next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && scan_res.produced |=> o_out_valid)
        else $error("produced result not presented");

endmodule
